// File: rtl/pps_pkg.sv
package pps_pkg;

    // result status codes
    localparam logic [1:0] STAT_LOADED = 2'd0;
    localparam logic [1:0] STAT_REJECT = 2'd1;
    localparam logic [1:0] STAT_RAN    = 2'd2;
    localparam logic [1:0] STAT_IDLE   = 2'd3;

    // input function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

    // controller to datapath commands
    typedef struct packed {
        logic accept;     // input transfer this cycle
        logic scan_issue; // read table entry at scan index
        logic read_pick;  // read picked entry, advance clock
        logic update;     // retire one unit of the picked task
        logic fin;        // form the waiting time
        logic out_load;   // move result into output register
    } pps_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic empty;      // no task loaded
        logic scan_last;  // scan index is at the last loaded entry
    } pps_stat_t;

endpackage

// File: rtl/preemptive_priority_scheduler_top.sv
// Channel  Direction  Handshake           Payload
// s_       in         s_valid / s_ready   s_func, s_arrival, s_burst, s_prio
// m_       out        m_valid / m_ready   m_status, m_proc_id, m_time_now, m_finished,
//                                         m_turnaround, m_waiting, m_all_done
//
// A load is staged in the result registers on input transfer and then moved to
// the output register. A tick scans the loaded entries, reading one table entry
// a cycle through the registered table read port, then runs DRAIN, READ, UPDATE, FIN.
// One item is in work at a time; a new item is taken while the last result
// waits in the output register. Reset is synchronous, active low, and clears
// the counters, clock and done mask; a result stalled by m_ready holds.
module preemptive_priority_scheduler_top #(
    parameter int MAX_PROCS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [15:0] s_arrival,
    input  logic [15:0] s_burst,
    input  logic [7:0]  s_prio,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [4:0]  m_proc_id,
    output logic [31:0] m_time_now,
    output logic        m_finished,
    output logic [31:0] m_turnaround,
    output logic [31:0] m_waiting,
    output logic        m_all_done
);

    pps_pkg::pps_cmd_t  cmd;
    pps_pkg::pps_stat_t stat;

    pps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_func),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd),
        .s_ready (s_ready),
        .m_valid (m_valid)
    );

    pps_dpath #(
        .MAX_PROCS (MAX_PROCS)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_func       (s_func),
        .s_arrival    (s_arrival),
        .s_burst      (s_burst),
        .s_prio       (s_prio),
        .m_status     (m_status),
        .m_proc_id    (m_proc_id),
        .m_time_now   (m_time_now),
        .m_finished   (m_finished),
        .m_turnaround (m_turnaround),
        .m_waiting    (m_waiting),
        .m_all_done   (m_all_done)
    );

    // one item in work at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while an item is in work");

    // completion only on a tick that ran a task
    a_fin_ran: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_finished) |-> (m_status == pps_pkg::STAT_RAN))
        else $error("finished set on a result that did not run a task");

    // times are zero unless a task completed
    a_zero_times: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_finished) |-> ((m_turnaround == 32'd0) && (m_waiting == 32'd0)))
        else $error("times reported without completion");

    // waiting never exceeds turnaround
    a_wait_le_tat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_finished) |-> (m_waiting <= m_turnaround))
        else $error("waiting exceeds turnaround");

endmodule

// File: rtl/pps_ctrl.sv
module pps_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_func,
    input  logic              m_ready,
    input  pps_pkg::pps_stat_t stat,
    output pps_pkg::pps_cmd_t  cmd,
    output logic              s_ready,
    output logic              m_valid
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SCAN   = 7'b0000010,
        ST_DRAIN  = 7'b0000100,
        ST_READ   = 7'b0001000,
        ST_UPDATE = 7'b0010000,
        ST_FIN    = 7'b0100000,
        ST_OUT    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    // next state and commands
    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.accept     = s_valid && (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_func == pps_pkg::FUNC_LOAD) begin
                        state_next = ST_OUT;
                    end else if (stat.empty) begin
                        state_next = ST_DRAIN;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan_issue = 1'b1;
                if (stat.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_READ;
            end
            ST_READ: begin
                cmd.read_pick = 1'b1;
                state_next    = ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                cmd.fin    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// File: rtl/pps_dpath.sv
module pps_dpath #(
    parameter int MAX_PROCS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  pps_pkg::pps_cmd_t  cmd,
    output pps_pkg::pps_stat_t stat,
    input  logic               s_func,
    input  logic [15:0]        s_arrival,
    input  logic [15:0]        s_burst,
    input  logic [7:0]         s_prio,
    output logic [1:0]         m_status,
    output logic [4:0]         m_proc_id,
    output logic [31:0]        m_time_now,
    output logic               m_finished,
    output logic [31:0]        m_turnaround,
    output logic [31:0]        m_waiting,
    output logic               m_all_done
);

    localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W = $clog2(MAX_PROCS + 1);

    // task tables
    logic [15:0] arr_mem   [MAX_PROCS];
    logic [15:0] burst_mem [MAX_PROCS];
    logic [7:0]  prio_mem  [MAX_PROCS];
    logic [15:0] rem_mem   [MAX_PROCS];
    logic [MAX_PROCS-1:0] done_mask_reg;

    logic [CNT_W-1:0] loaded_cnt_reg;
    logic [CNT_W-1:0] fin_cnt_reg;
    logic [31:0]      clock_reg;

    // scan state
    logic [IDX_W-1:0] scan_idx_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             cmp_vld_reg;
    logic             found_reg;
    logic [7:0]       best_reg;
    logic [IDX_W-1:0] pick_reg;

    // registered read data
    logic [IDX_W-1:0] rd_addr;
    logic             rd_en;
    logic [15:0]      arr_rd_reg;
    logic [15:0]      burst_rd_reg;
    logic [7:0]       prio_rd_reg;
    logic [15:0]      rem_rd_reg;

    // staged result
    logic [1:0]  res_status_reg;
    logic [4:0]  res_id_reg;
    logic        res_fin_reg;
    logic [31:0] res_tat_reg;
    logic [31:0] res_wt_reg;

    logic             do_load;
    logic             do_tick;
    logic             reject;
    logic [IDX_W-1:0] load_idx;
    logic             cand;
    logic [15:0]      rem_new;
    logic [CNT_W-1:0] last_idx;

    assign do_load  = cmd.accept && (s_func == pps_pkg::FUNC_LOAD);
    assign do_tick  = cmd.accept && (s_func == pps_pkg::FUNC_TICK);
    assign reject   = (s_burst == 16'd0) || (loaded_cnt_reg >= CNT_W'(MAX_PROCS));
    assign load_idx = loaded_cnt_reg[IDX_W-1:0];
    assign last_idx = CNT_W'(loaded_cnt_reg - 1'b1);

    assign stat.empty     = (loaded_cnt_reg == '0);
    assign stat.scan_last = (CNT_W'(scan_idx_reg) == last_idx);

    assign rd_addr = cmd.read_pick ? pick_reg : scan_idx_reg;
    assign rd_en   = cmd.scan_issue || cmd.read_pick;

    // candidate test on the entry read last cycle
    assign cand = cmp_vld_reg && !done_mask_reg[cmp_idx_reg] &&
                  ({16'd0, arr_rd_reg} <= clock_reg) &&
                  (!found_reg || (prio_rd_reg > best_reg));

    assign rem_new = rem_rd_reg - 16'd1;

    // table write and read ports
    always_ff @(posedge aclk) begin
        if (do_load && !reject) begin
            arr_mem[load_idx]   <= s_arrival;
            burst_mem[load_idx] <= s_burst;
            prio_mem[load_idx]  <= s_prio;
        end
        if (rd_en) begin
            arr_rd_reg   <= arr_mem[rd_addr];
            burst_rd_reg <= burst_mem[rd_addr];
            prio_rd_reg  <= prio_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (do_load && !reject) begin
            rem_mem[load_idx] <= s_burst;
        end else if (cmd.update && found_reg) begin
            rem_mem[pick_reg] <= rem_new;
        end
        if (rd_en) begin
            rem_rd_reg <= rem_mem[rd_addr];
        end
    end

    // counters, clock and done mask
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loaded_cnt_reg <= '0;
            fin_cnt_reg    <= '0;
            clock_reg      <= '0;
            done_mask_reg  <= '0;
            cmp_vld_reg    <= 1'b0;
        end else begin
            cmp_vld_reg <= cmd.scan_issue;
            if (do_load && !reject) begin
                loaded_cnt_reg          <= loaded_cnt_reg + 1'b1;
                done_mask_reg[load_idx] <= 1'b0;
            end
            if (cmd.read_pick && (clock_reg != pps_pkg::TIME_MAX)) begin
                clock_reg <= clock_reg + 32'd1;
            end
            if (cmd.update && found_reg && (rem_new == 16'd0)) begin
                done_mask_reg[pick_reg] <= 1'b1;
                fin_cnt_reg             <= fin_cnt_reg + 1'b1;
            end
        end
    end

    // priority scan
    always_ff @(posedge aclk) begin
        cmp_idx_reg <= scan_idx_reg;
        if (do_tick) begin
            scan_idx_reg <= '0;
            found_reg    <= 1'b0;
            best_reg     <= '0;
            pick_reg     <= '0;
        end else begin
            if (cmd.scan_issue) begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
            if (cand) begin
                found_reg <= 1'b1;
                best_reg  <= prio_rd_reg;
                pick_reg  <= cmp_idx_reg;
            end
        end
    end

    // result staging
    always_ff @(posedge aclk) begin
        if (do_load) begin
            res_fin_reg <= 1'b0;
            res_tat_reg <= '0;
            res_wt_reg  <= '0;
            if (reject) begin
                res_status_reg <= pps_pkg::STAT_REJECT;
                res_id_reg     <= '0;
            end else begin
                res_status_reg <= pps_pkg::STAT_LOADED;
                res_id_reg     <= 5'(loaded_cnt_reg + 1'b1);
            end
        end
        if (cmd.update) begin
            res_wt_reg <= '0;
            if (found_reg) begin
                res_status_reg <= pps_pkg::STAT_RAN;
                res_id_reg     <= 5'(pick_reg + 1'b1);
                if (rem_new == 16'd0) begin
                    res_fin_reg <= 1'b1;
                    res_tat_reg <= clock_reg - {16'd0, arr_rd_reg};
                end else begin
                    res_fin_reg <= 1'b0;
                    res_tat_reg <= '0;
                end
            end else begin
                res_status_reg <= pps_pkg::STAT_IDLE;
                res_id_reg     <= '0;
                res_fin_reg    <= 1'b0;
                res_tat_reg    <= '0;
            end
        end
        // waiting is clamped at zero once the clock has saturated
        if (cmd.fin) begin
            if (res_fin_reg && (res_tat_reg >= {16'd0, burst_rd_reg})) begin
                res_wt_reg <= res_tat_reg - {16'd0, burst_rd_reg};
            end else begin
                res_wt_reg <= '0;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_status     <= res_status_reg;
            m_proc_id    <= res_id_reg;
            m_time_now   <= clock_reg;
            m_finished   <= res_fin_reg;
            m_turnaround <= res_tat_reg;
            m_waiting    <= res_wt_reg;
            m_all_done   <= (fin_cnt_reg == loaded_cnt_reg);
        end
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int N_TASKS        = 16;
    localparam int N_RANDOM       = 1850;
    localparam int QUIET_TAIL     = 200;   // last items run with no idling
    localparam int WATCHDOG_LIMIT = 3000;  // cycles without any transfer
    localparam int DRAIN_CYCLES   = 60;    // > tick latency at a full table

    // one input item, plus a flag that makes the sender wait for all results
    typedef struct packed {
        logic        func;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [7:0]  prio;
        logic        hold;
    } sched_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  proc_id;
        logic [31:0] time_now;
        logic        finished;
        logic [31:0] turnaround;
        logic [31:0] waiting;
        logic        all_done;
    } sched_result_t;

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic        s_func       = pps_pkg::FUNC_TICK;
    logic [15:0] s_arrival    = '0;
    logic [15:0] s_burst      = '0;
    logic [7:0]  s_prio       = '0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic [1:0]  m_status;
    logic [4:0]  m_proc_id;
    logic [31:0] m_time_now;
    logic        m_finished;
    logic [31:0] m_turnaround;
    logic [31:0] m_waiting;
    logic        m_all_done;

    sched_item_t   pend_q[$];
    sched_result_t sched_q[$];
    sched_item_t   cur_item;
    sched_result_t want;
    int            err_cnt      = 0;
    int            send_gap     = 0;
    int            recv_stall   = 0;
    int            stall_cycles = 0;
    int unsigned   gen_time     = 0;

    // scheduler state mirror
    logic [15:0] task_arrival [N_TASKS] = '{default: '0};
    logic [15:0] task_burst   [N_TASKS] = '{default: '0};
    logic [7:0]  task_prio    [N_TASKS] = '{default: '0};
    logic [15:0] task_left    [N_TASKS] = '{default: '0};
    logic        task_done    [N_TASKS] = '{default: 1'b0};
    int          n_loaded   = 0;
    int          n_finished = 0;
    logic [31:0] sim_clock  = '0;

    always #6 aclk = ~aclk;

    preemptive_priority_scheduler_top #(
        .MAX_PROCS(N_TASKS)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_arrival   (s_arrival),
        .s_burst     (s_burst),
        .s_prio      (s_prio),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_proc_id   (m_proc_id),
        .m_time_now  (m_time_now),
        .m_finished  (m_finished),
        .m_turnaround(m_turnaround),
        .m_waiting   (m_waiting),
        .m_all_done  (m_all_done)
    );

    // load a task or run one time unit, return the scheduler's report
    function automatic sched_result_t run_scheduler(sched_item_t it);
        sched_result_t r;
        int          pick;
        logic [7:0]  best;
        logic [31:0] tat;
        r    = '0;
        pick = -1;
        best = '0;
        if (it.func == pps_pkg::FUNC_LOAD) begin
            if (it.burst == 16'd0 || n_loaded >= N_TASKS) begin
                r.status = pps_pkg::STAT_REJECT;
            end else begin
                task_arrival[n_loaded] = it.arrival;
                task_burst[n_loaded]   = it.burst;
                task_prio[n_loaded]    = it.prio;
                task_left[n_loaded]    = it.burst;
                task_done[n_loaded]    = 1'b0;
                n_loaded++;
                r.status  = pps_pkg::STAT_LOADED;
                r.proc_id = 5'(n_loaded);
            end
        end else begin
            // highest priority ready task, strict compare keeps the lowest id
            for (int i = 0; i < n_loaded; i++) begin
                if (!task_done[i] && 32'(task_arrival[i]) <= sim_clock &&
                    (pick < 0 || task_prio[i] > best)) begin
                    pick = i;
                    best = task_prio[i];
                end
            end
            if (sim_clock != pps_pkg::TIME_MAX)
                sim_clock = sim_clock + 32'd1;
            if (pick < 0) begin
                r.status = pps_pkg::STAT_IDLE;
            end else begin
                r.status        = pps_pkg::STAT_RAN;
                r.proc_id       = 5'(pick + 1);
                task_left[pick] = task_left[pick] - 16'd1;
                if (task_left[pick] == 16'd0) begin
                    tat             = sim_clock - 32'(task_arrival[pick]);
                    task_done[pick] = 1'b1;
                    n_finished++;
                    r.finished   = 1'b1;
                    r.turnaround = tat;
                    r.waiting    = (tat >= 32'(task_burst[pick])) ?
                                   tat - 32'(task_burst[pick]) : 32'd0;
                end
            end
        end
        r.time_now = sim_clock;
        r.all_done = (n_finished == n_loaded);
        return r;
    endfunction

    function automatic bit quiet_phase();
        return pend_q.size() < QUIET_TAIL;
    endfunction

    task automatic queue_load(input logic [15:0] a, input logic [15:0] b,
                              input logic [7:0] p, input logic hold);
        pend_q.push_back('{func: pps_pkg::FUNC_LOAD, arrival: a, burst: b, prio: p,
                           hold: hold});
    endtask

    // tick with junk in the fields that a tick ignores
    task automatic queue_tick(input logic hold);
        pend_q.push_back('{func: pps_pkg::FUNC_TICK, arrival: 16'($urandom),
                           burst: 16'($urandom), prio: 8'($urandom), hold: hold});
        gen_time++;
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (act_val !== exp_val) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_val, act_val);
        end
    endtask

    // stimulus, reset and end of run
    initial begin
        logic [15:0] arr;
        logic [15:0] bst;
        logic [7:0]  pri;

        // directed: empty table, rejects, ties, preemption, field extremes
        queue_tick(1'b0);
        queue_load(16'd0, 16'd0, 8'hFF, 1'b0);
        queue_load(16'd0, 16'd1, 8'hFF, 1'b0);
        queue_tick(1'b0);
        queue_tick(1'b0);
        queue_load(16'hFFFF, 16'hFFFF, 8'hFF, 1'b0);
        queue_load(16'd0, 16'd2, 8'h00, 1'b0);
        queue_load(16'd0, 16'd2, 8'h00, 1'b0);
        queue_load(16'd4, 16'd1, 8'h80, 1'b0);
        queue_load(16'd5, 16'd0, 8'h7F, 1'b0);
        repeat (7) queue_tick(1'b0);
        queue_load(16'd0, 16'hFFFE, 8'h00, 1'b1);
        repeat (3) queue_tick(1'b0);

        // random: mostly ticks, sparse loads so tasks run through the table
        for (int n = 0; n < N_RANDOM; n++) begin
            if ($urandom_range(0, 99) < 4) begin
                case ($urandom_range(0, 7))
                    0:       bst = 16'd0;
                    1:       bst = 16'($urandom_range(100, 400));
                    default: bst = 16'($urandom_range(1, 25));
                endcase
                case ($urandom_range(0, 5))
                    0:       arr = 16'($urandom_range(0, gen_time));
                    1:       arr = 16'($urandom);
                    default: arr = 16'(gen_time + $urandom_range(0, 40));
                endcase
                pri = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
                queue_load(arr, bst, pri, (n % 450) == 0);
            end else begin
                queue_tick((n % 450) == 0);
            end
        end
        // full table is expected to be hit here
        repeat (2) queue_load(16'd0, 16'd3, 8'hFF, 1'b0);
        repeat (3) queue_tick(1'b0);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (pend_q.size() != 0 || s_valid)
            @(posedge aclk);
        while (sched_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (err_cnt == 0 && sched_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // driver: present the next pending item, predict on each transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                sched_q.push_back(run_scheduler(cur_item));
                if (!quiet_phase() && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 19);
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pend_q.size() != 0 &&
                             !(pend_q[0].hold && sched_q.size() != 0)) begin
                    cur_item = pend_q.pop_front();
                    s_valid   <= 1'b1;
                    s_func    <= cur_item.func;
                    s_arrival <= cur_item.arrival;
                    s_burst   <= cur_item.burst;
                    s_prio    <= cur_item.prio;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result transfer, random backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (sched_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: result with none expected, status %0d id %0d",
                             $time, m_status, m_proc_id);
                end else begin
                    want = sched_q.pop_front();
                    check_field("status",     32'(want.status),   32'(m_status));
                    check_field("proc_id",    32'(want.proc_id),  32'(m_proc_id));
                    check_field("time_now",   want.time_now,      m_time_now);
                    check_field("finished",   32'(want.finished), 32'(m_finished));
                    check_field("turnaround", want.turnaround,    m_turnaround);
                    check_field("waiting",    want.waiting,       m_waiting);
                    check_field("all_done",   32'(want.all_done), 32'(m_all_done));
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!quiet_phase() && $urandom_range(0, 6) == 0)
                    recv_stall = $urandom_range(1, 19);
            end
        end
    end

    // watchdog: no transfer on either side for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule

// File: files.f
rtl/pps_pkg.sv
rtl/pps_ctrl.sv
rtl/pps_dpath.sv
rtl/preemptive_priority_scheduler_top.sv
tb/tb_top.sv
